/* hdl/fffa_pkg.sv */
package fffa_pkg;

	localparam int MAX_REQUEST = 125;

	localparam logic [2:0] CMD_ALLOC  = 3'd0;
	localparam logic [2:0] CMD_FREE   = 3'd1;
	localparam logic [2:0] CMD_FILL   = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_HEADER = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_TOO_BIG   = 3'd4;
	localparam logic [2:0] ST_OFFSET    = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] block_id;
		logic [6:0] byte_count;
		logic [7:0] fill_char;
		logic [6:0] offset;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] result_id;
		logic [7:0] data_byte;
	} res_word_t;

	typedef struct packed {
		logic       rd;
		logic       we;
		logic [7:0] addr;
		logic [7:0] wdata;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SIZE,
		S_ID,
		S_EVAL,
		S_WRITE,
		S_RWAIT,
		S_DONE
	} seq_state_t;

endpackage

/* hdl/fffa_heap_mem.sv */
module fffa_heap_mem import fffa_pkg::*; #(
	parameter int HEAP_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rdata
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam logic [7:0] INIT_SIZE = 8'(((HEAP_BYTES - 1) * 2) % 256);

	logic [7:0]    heap_q [HEAP_BYTES];
	logic          valid_q [HEAP_BYTES];
	logic [7:0]    rdata_q;
	logic [7:0]    init_q;
	logic          hit_q;
	logic [AW-1:0] a;

	assign a = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			heap_q[a] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= heap_q[a];
			init_q  <= (a == AW'(1)) ? INIT_SIZE : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEAP_BYTES; i++) begin
				valid_q[i] <= 1'b0;
			end
			hit_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[a] <= 1'b1;
			end
			if (req.rd) begin
				hit_q <= valid_q[a];
			end
		end
	end

	assign rdata = hit_q ? rdata_q : init_q;

endmodule

/* hdl/fffa_seq.sv */
module fffa_seq import fffa_pkg::*; #(
	parameter int HEAP_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_word_t  cmd_word,
	output logic       busy,
	output mem_req_t   mem_req,
	input  logic [7:0] mem_rdata,
	output logic       done,
	output res_word_t  result,
	input  logic       res_free
);

	seq_state_t state_q, state_d;
	cmd_word_t  cmd_q;
	res_word_t  res_q;
	logic [7:0] pos_q;
	logic [7:0] size_q;
	logic [7:0] id_cnt_q;
	logic [6:0] step_q;
	logic       split_q;
	logic [7:0] rest_q;

	logic [7:0] total;
	logic [7:0] need;
	logic [7:0] payload;
	logic [7:0] pos_next;
	logic       end_walk;
	logic       fits;
	logic       match;
	logic       bad_size;
	logic       last_step;
	logic [8:0] waddr;
	logic [7:0] wdata;

	assign total    = {1'b0, size_q[7:1]} + 8'd1;
	assign need     = {1'b0, cmd_q.byte_count} + 8'd2;
	assign payload  = total - 8'd2;
	assign pos_next = pos_q + total;
	assign end_walk = ({1'b0, pos_q} + 9'd1) >= 9'(HEAP_BYTES);
	assign fits     = !size_q[0] && (need <= total);
	assign match    = size_q[0] && (mem_rdata == cmd_q.block_id);
	assign bad_size = (cmd_q.byte_count == 7'd0) || (cmd_q.byte_count > 7'(MAX_REQUEST));

	always_comb begin
		waddr = 9'd0;
		wdata = 8'd0;
		last_step = 1'b1;
		unique case (cmd_q.command)
			CMD_ALLOC: begin
				last_step = split_q ? (step_q == 7'd3) : (step_q == 7'd1);
				case (step_q[1:0])
					2'd0: begin
						waddr = {1'b0, pos_q};
						wdata = res_q.result_id;
					end
					2'd1: begin
						waddr = {1'b0, pos_q} + 9'd1;
						wdata = split_q ? {cmd_q.byte_count + 7'd1, 1'b1} : (size_q | 8'd1);
					end
					2'd2: begin
						waddr = {1'b0, pos_q} + {1'b0, need};
						wdata = 8'd0;
					end
					default: begin
						waddr = {1'b0, pos_q} + {1'b0, need} + 9'd1;
						wdata = {rest_q[6:0] - 7'd1, 1'b0};
					end
				endcase
			end
			CMD_FREE: begin
				last_step = (step_q == 7'd1);
				waddr = {1'b0, pos_q} + {8'd0, step_q[0]};
				wdata = step_q[0] ? {size_q[7:1], 1'b0} : 8'd0;
			end
			default: begin
				last_step = (step_q == cmd_q.byte_count - 7'd1);
				waddr = {1'b0, pos_q} + 9'd2 + {2'b0, step_q};
				wdata = cmd_q.fill_char;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (cmd_q.command > CMD_HEADER) begin
					state_d = S_DONE;
				end else if (cmd_q.command == CMD_ALLOC && bad_size) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SIZE;
				end
			end
			S_SIZE: begin
				state_d = end_walk ? S_DONE : S_ID;
			end
			S_ID: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (cmd_q.command == CMD_ALLOC) begin
					state_d = fits ? S_WRITE : S_SIZE;
				end else if (!match) begin
					state_d = S_SIZE;
				end else begin
					unique case (cmd_q.command)
						CMD_FREE: state_d = S_WRITE;
						CMD_FILL: begin
							if ({1'b0, cmd_q.byte_count} > payload || cmd_q.byte_count == 7'd0) begin
								state_d = S_DONE;
							end else begin
								state_d = S_WRITE;
							end
						end
						CMD_READ: state_d = ({1'b0, cmd_q.offset} >= payload) ? S_DONE : S_RWAIT;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_WRITE: begin
				if (last_step) begin
					state_d = S_DONE;
				end
			end
			S_RWAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_SIZE: begin
				mem_req.rd   = !end_walk;
				mem_req.addr = pos_q + 8'd1;
			end
			S_ID: begin
				mem_req.rd   = 1'b1;
				mem_req.addr = pos_q;
			end
			S_EVAL: begin
				mem_req.rd   = cmd_q.command == CMD_READ;
				mem_req.addr = pos_q + 8'd2 + {1'b0, cmd_q.offset};
			end
			S_WRITE: begin
				mem_req.we    = waddr < 9'(HEAP_BYTES);
				mem_req.addr  = waddr[7:0];
				mem_req.wdata = wdata;
			end
			default: mem_req = '0;
		endcase
	end

	assign busy   = state_q != S_IDLE;
	assign done   = state_q == S_DONE;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			id_cnt_q <= 8'd0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EVAL && cmd_q.command == CMD_ALLOC && fits) begin
				id_cnt_q <= id_cnt_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd_word;
				end
			end
			S_START: begin
				res_q  <= '0;
				pos_q  <= 8'd0;
				step_q <= 7'd0;
				if (cmd_q.command == CMD_ALLOC && bad_size) begin
					res_q.status <= ST_BAD_SIZE;
				end
			end
			S_SIZE: begin
				if (end_walk) begin
					res_q.status <= (cmd_q.command == CMD_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
				end
			end
			S_ID: begin
				size_q <= mem_rdata;
			end
			S_EVAL: begin
				pos_q   <= pos_next;
				rest_q  <= total - need;
				split_q <= (total - need) > 8'd2;
				if (cmd_q.command == CMD_ALLOC) begin
					if (fits) begin
						pos_q           <= pos_q;
						res_q.result_id <= id_cnt_q + 8'd1;
					end
				end else if (match) begin
					pos_q <= pos_q;
					case (cmd_q.command)
						CMD_FILL: begin
							if ({1'b0, cmd_q.byte_count} > payload) begin
								res_q.status <= ST_TOO_BIG;
							end
						end
						CMD_READ: begin
							if ({1'b0, cmd_q.offset} >= payload) begin
								res_q.status <= ST_OFFSET;
							end
						end
						CMD_HEADER: begin
							res_q.result_id <= mem_rdata;
							res_q.data_byte <= size_q + 8'd2;
						end
						default: ;
					endcase
				end
			end
			S_WRITE: begin
				step_q <= step_q + 7'd1;
			end
			S_RWAIT: begin
				res_q.data_byte <= mem_rdata;
			end
			default: ;
		endcase
	end

	a_no_rd_we: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd && mem_req.we))
		else $error("heap read and write issued together");

	a_id_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(id_cnt_q) |-> $past(cmd_q.command) == CMD_ALLOC)
		else $error("id counter moved outside allocate");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !busy) |=> state_q == S_START)
		else $error("accepted word did not start the sequencer");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> (!mem_req.we && !mem_req.rd))
		else $error("heap accessed while no command is active");

endmodule

/* hdl/first_fit_heap_allocator.sv */
// First-fit heap allocator over a byte heap of implicit blocks, each with an id byte and a
// size/allocated byte. One command word is taken at a time and gives exactly one result word.
// The heap is a single-port memory and the sequencer walks block headers one block at a time,
// with a size read, an id read and a compare for each block; fill then writes its requested
// bytes one by one, and allocate adds two or four header writes.
// No clearing pass follows reset: per-byte valid bits make the heap read as its reset image.
module first_fit_heap_allocator import fffa_pkg::*; #(
	parameter int HEAP_BYTES = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	mem_req_t   mem_req;
	logic [7:0] mem_rdata;
	logic       busy;
	logic       done;
	logic       res_free;
	res_word_t  result;
	logic       res_valid_q;
	res_word_t  res_word_q;

	assign res_free  = !res_valid_q || !res_stall;
	assign cmd_stall = busy;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	fffa_heap_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	fffa_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_word  (cmd_word),
		.busy      (busy),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.done      (done),
		.result    (result),
		.res_free  (res_free)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res_free) begin
			res_word_q <= result;
		end
	end

endmodule
